>>> rtl/core/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants of the HSV to RGB pixel converter: sector codes,
// channel widths and the reciprocal constants of the two constant dividers.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int ChanW = 8;

  // Hue arithmetic: h2 = 2*hue, one sector spans 85 steps of h2
  localparam int HueDblW = ChanW + 1;
  localparam int RemW = 7;
  localparam logic [HueDblW-1:0] SECTOR_SPAN = HueDblW'(85);

  // Hue sectors; the wrap code comes from hue 255 and acts like the red one
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5,
    SEC_WRAP    = 3'd6
  } sector_e;

  // v*s and v*s*rem widths
  localparam int VsW = 2 * ChanW;
  localparam int VsrW = VsW + RemW;

  // ceil(x/255) = floor((x + 254) / 255), by a multiply with a rounded-up
  // reciprocal; exact for every numerator below 2^FULL_SHIFT / 255
  localparam int FULL_SCALE = 255;
  localparam int FullNumW = VsW + 1;
  localparam int FULL_SHIFT = 25;
  localparam logic [63:0] FullRecip64 =
    ((64'd1 << FULL_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam int FullRecipW = 18;
  localparam logic [FullRecipW-1:0] FULL_RECIP = FullRecip64[FullRecipW-1:0];
  localparam logic [FullNumW-1:0] FULL_BIAS = FullNumW'(FULL_SCALE - 1);
  localparam int FullProdW = FullNumW + FullRecipW;

  // floor and ceil of x/21675 (21675 = 255 * 85), same scheme
  localparam int FRAC_SCALE = 21675;
  localparam int FRAC_SHIFT = 38;
  localparam logic [63:0] FracRecip64 =
    ((64'd1 << FRAC_SHIFT) + 64'(FRAC_SCALE) - 64'd1) / 64'(FRAC_SCALE);
  localparam int FracRecipW = 24;
  localparam logic [FracRecipW-1:0] FRAC_RECIP = FracRecip64[FracRecipW-1:0];
  localparam logic [VsrW-1:0] FRAC_BIAS = VsrW'(FRAC_SCALE - 1);
  localparam int FracProdW = VsrW + FracRecipW;

endpackage

>>> rtl/core/hsvrgb_sector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Splits the hue byte into its sector and the position inside the sector:
// sector = floor(2h/85), rem = 2h mod 85, by comparing against multiples.
// ----------------------------------------------------------------------------
module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic [ChanW-1:0] hue_i,
  output sector_e          sector_o,
  output logic [RemW-1:0]  rem_o
);

  logic [HueDblW-1:0] h2;
  logic [HueDblW-1:0] base;

  assign h2 = {hue_i, 1'b0};

  always_comb begin
    if (h2 >= HueDblW'(6 * 85)) begin
      sector_o = SEC_WRAP;
      base     = HueDblW'(6 * 85);
    end else if (h2 >= HueDblW'(5 * 85)) begin
      sector_o = SEC_MAGENTA;
      base     = HueDblW'(5 * 85);
    end else if (h2 >= HueDblW'(4 * 85)) begin
      sector_o = SEC_BLUE;
      base     = HueDblW'(4 * 85);
    end else if (h2 >= HueDblW'(3 * 85)) begin
      sector_o = SEC_CYAN;
      base     = HueDblW'(3 * 85);
    end else if (h2 >= HueDblW'(2 * 85)) begin
      sector_o = SEC_GREEN;
      base     = HueDblW'(2 * 85);
    end else if (h2 >= SECTOR_SPAN) begin
      sector_o = SEC_YELLOW;
      base     = SECTOR_SPAN;
    end else begin
      sector_o = SEC_RED;
      base     = '0;
    end
  end

  // Difference is always below 85
  logic [HueDblW-1:0] rem_full;
  assign rem_full = h2 - base;
  assign rem_o    = rem_full[RemW-1:0];

endmodule

>>> rtl/core/hsv_to_rgb_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// Converts 8-bit HSV pixels into 8-bit RGB in a four-stage pipeline.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the output is not stalled. Results
// come out in order, one per pixel, through the four register stages: the
// first loads at the input transfer with the sector split and v*s. The second
// forms v*s*rem and the reciprocal product for the divide by 255. The third
// does the reciprocal divide by 21675 and forms p. The fourth is the output
// register, loaded with the channel select. Each stage holds while the stage
// after it is full and stalled. Back pressure on the output therefore ripples
// back to in_ready_o without loss. Zero saturation yields grey (v,v,v); hue
// 255 wraps into the red sector.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_unit import hsvrgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] brightness_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic valid1_q, valid2_q, valid3_q, valid4_q;
  logic ready1, ready2, ready3, ready4;

  assign ready4     = !valid4_q || out_ready_i;
  assign ready3     = !valid3_q || ready4;
  assign ready2     = !valid2_q || ready3;
  assign ready1     = !valid1_q || ready2;
  assign in_ready_o = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (ready1) valid1_q <= in_valid_i;
      if (ready2) valid2_q <= valid1_q;
      if (ready3) valid3_q <= valid2_q;
      if (ready4) valid4_q <= valid3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sector split, v*s
  // --------------------------------------------------------------------------
  sector_e         sector;
  logic [RemW-1:0] rem;

  hsvrgb_sector u_sector (
    .hue_i    (hue_i),
    .sector_o (sector),
    .rem_o    (rem)
  );

  sector_e          sector1_q;
  logic [RemW-1:0]  rem1_q;
  logic [VsW-1:0]   vs1_q;
  logic [ChanW-1:0] v1_q;
  logic             grey1_q;

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      sector1_q <= sector;
      rem1_q    <= rem;
      vs1_q     <= VsW'(brightness_i) * VsW'(saturation_i);
      v1_q      <= brightness_i;
      grey1_q   <= (saturation_i == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: v*s*rem, and ceil(v*s/255) by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [FullNumW-1:0] full_num;
  assign full_num = FullNumW'(vs1_q) + FULL_BIAS;

  sector_e              sector2_q;
  logic [VsrW-1:0]      vsr2_q;
  logic [FullProdW-1:0] pprod2_q;
  logic [ChanW-1:0]     v2_q;
  logic                 grey2_q;

  always_ff @(posedge clk_i) begin
    if (ready2 && valid1_q) begin
      sector2_q <= sector1_q;
      vsr2_q    <= VsrW'(vs1_q) * VsrW'(rem1_q);
      pprod2_q  <= FullProdW'(full_num) * FullProdW'(FULL_RECIP);
      v2_q      <= v1_q;
      grey2_q   <= grey1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: floor and ceil of v*s*rem/21675, p = v - ceil(v*s/255)
  // --------------------------------------------------------------------------
  logic [FullProdW-1:0] pdiv;
  logic [VsrW-1:0]      frac_num_ceil;
  logic [FracProdW-1:0] fprod_floor, fprod_ceil;
  logic [FracProdW-1:0] fdiv_floor, fdiv_ceil;

  assign pdiv          = pprod2_q >> FULL_SHIFT;
  assign frac_num_ceil = vsr2_q + FRAC_BIAS;
  assign fprod_floor   = FracProdW'(vsr2_q) * FracProdW'(FRAC_RECIP);
  assign fprod_ceil    = FracProdW'(frac_num_ceil) * FracProdW'(FRAC_RECIP);
  assign fdiv_floor    = fprod_floor >> FRAC_SHIFT;
  assign fdiv_ceil     = fprod_ceil >> FRAC_SHIFT;

  sector_e          sector3_q;
  logic [ChanW-1:0] p3_q, fl3_q, cl3_q, v3_q;
  logic             grey3_q;

  always_ff @(posedge clk_i) begin
    if (ready3 && valid2_q) begin
      sector3_q <= sector2_q;
      p3_q      <= v2_q - pdiv[ChanW-1:0];
      fl3_q     <= fdiv_floor[ChanW-1:0];
      cl3_q     <= fdiv_ceil[ChanW-1:0];
      v3_q      <= v2_q;
      grey3_q   <= grey2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: q, t and channel order into the output register
  // --------------------------------------------------------------------------
  logic [ChanW-1:0] q_val, t_val;
  logic [ChanW-1:0] red_d, green_d, blue_d;

  assign q_val = v3_q - cl3_q;
  assign t_val = p3_q + fl3_q;

  always_comb begin
    if (grey3_q) begin
      red_d   = v3_q;
      green_d = v3_q;
      blue_d  = v3_q;
    end else begin
      case (sector3_q)
        SEC_YELLOW: begin
          red_d = q_val; green_d = v3_q; blue_d = p3_q;
        end
        SEC_GREEN: begin
          red_d = p3_q; green_d = v3_q; blue_d = t_val;
        end
        SEC_CYAN: begin
          red_d = p3_q; green_d = q_val; blue_d = v3_q;
        end
        SEC_BLUE: begin
          red_d = t_val; green_d = p3_q; blue_d = v3_q;
        end
        SEC_MAGENTA: begin
          red_d = v3_q; green_d = p3_q; blue_d = q_val;
        end
        default: begin
          red_d = v3_q; green_d = t_val; blue_d = p3_q;
        end
      endcase
    end
  end

  logic [ChanW-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (ready4 && valid3_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = valid4_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule
